>>> rtl/apci_fx_pkg.sv
// Shared types and constants for the APCI frame extractor.
`timescale 1ns / 1ps
`default_nettype none

package apci_fx_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFFSET_W = 9;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] START_CODE_RESET = 8'd104;
  localparam logic [BYTE_W-1:0] MIN_LENGTH_RESET = 8'd4;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_START_CODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 1'd1;

  // Result queue depth; must hold two results from one byte plus slack
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic [OFFSET_W-1:0] offset;
    logic                frame_first;
    logic                frame_last;
    logic                run_last;
  } res_t;

  typedef struct packed {
    logic first;   // write entry 0
    logic second;  // write entry 1 as well
  } push_t;

endpackage

`default_nettype wire

>>> rtl/apci_fx_if.sv
// Byte and result channel interfaces of the APCI frame extractor.
`timescale 1ns / 1ps
`default_nettype none

interface apci_fx_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface apci_fx_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [8:0] offset;
  logic       frame_first;
  logic       frame_last;
  logic       run_last;

  modport source (output valid, output out_byte, output offset, output frame_first,
                  output frame_last, output run_last, input ready);
  modport sink   (input valid, input out_byte, input offset, input frame_first,
                  input frame_last, input run_last, output ready);
endinterface

`default_nettype wire

>>> rtl/apci_fx_queue.sv
// Small result queue taking up to two results per cycle and giving one when the head is taken.
`timescale 1ns / 1ps
`default_nettype none

module apci_fx_queue
  import apci_fx_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  input  wire res_t  entry0,
  input  wire res_t  entry1,
  output logic       room,
  output logic       head_valid,
  output res_t       head,
  input  wire logic  head_take
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  res_t            slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic [PW-1:0]   wr_ptr_1;
  logic [PW-1:0]   wr_ptr_next;
  logic [CW-1:0]   count_next;
  logic            pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign pop        = head_valid && head_take;
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  // room for the worst case of two results
  assign room       = (count <= CW'(DEPTH - 2));
  assign wr_ptr_1   = ptr_inc(wr_ptr);

  always_comb begin
    wr_ptr_next = wr_ptr;
    if (push.second) begin
      wr_ptr_next = ptr_inc(wr_ptr_1);
    end else if (push.first) begin
      wr_ptr_next = wr_ptr_1;
    end
    count_next = count + CW'(push.first) + CW'(push.second) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      slots[wr_ptr] <= entry0;
    end
    if (push.second) begin
      slots[wr_ptr_1] <= entry1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("result queue overfilled");

  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    push.second |-> push.first)
    else $error("second result pushed without the first");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (count == '0) && (wr_ptr == rd_ptr))
    else $error("queue not empty after reset");

endmodule

`default_nettype wire

>>> rtl/apci_fx_core.sv
// Framing state machine of the APCI frame extractor.
`timescale 1ns / 1ps
`default_nettype none

module apci_fx_core
  import apci_fx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire logic [BYTE_W-1:0] start_code,
  input  wire logic [BYTE_W-1:0] min_length,
  output push_t                  push,
  output res_t                   entry0,
  output res_t                   entry1
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_BODY
  } phase_t;

  phase_t              phase;
  phase_t              phase_next;
  logic [BYTE_W-1:0]   bytes_left;
  logic [BYTE_W-1:0]   bytes_left_next;
  logic [OFFSET_W-1:0] position;
  logic [OFFSET_W-1:0] position_next;
  logic                is_start;
  logic                body_last;

  assign is_start  = (rx_byte == start_code);
  assign body_last = (bytes_left <= BYTE_W'(1));

  always_comb begin
    phase_next      = phase;
    bytes_left_next = bytes_left;
    position_next   = position;
    push            = '0;
    entry0          = '0;
    entry1          = '0;
    case (phase)
      PH_LEN: begin
        if (rx_byte < min_length) begin
          // rejected length may itself open a new frame
          phase_next = is_start ? PH_LEN : PH_HUNT;
        end else begin
          push.first         = 1'b1;
          push.second        = 1'b1;
          entry0.out_byte    = start_code;
          entry0.offset      = '0;
          entry0.frame_first = 1'b1;
          entry1.out_byte    = rx_byte;
          entry1.offset      = OFFSET_W'(1);
          entry1.frame_last  = (rx_byte == '0);
          entry1.run_last    = 1'b1;
          bytes_left_next    = rx_byte;
          position_next      = OFFSET_W'(2);
          phase_next         = (rx_byte == '0) ? PH_HUNT : PH_BODY;
        end
      end
      PH_BODY: begin
        push.first        = 1'b1;
        entry0.out_byte   = rx_byte;
        entry0.offset     = position;
        entry0.frame_last = body_last;
        entry0.run_last   = 1'b1;
        position_next     = position + OFFSET_W'(1);
        bytes_left_next   = (bytes_left == '0) ? '0 : bytes_left - BYTE_W'(1);
        if (body_last) begin
          phase_next = PH_HUNT;
        end
      end
      default: begin
        phase_next = is_start ? PH_LEN : PH_HUNT;
      end
    endcase
    if (!take) begin
      push = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      bytes_left <= '0;
      position   <= '0;
    end else if (take) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      position   <= position_next;
    end
  end

  a_body_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (bytes_left != '0))
    else $error("in frame with no bytes left");

  a_pair_only_on_len: assert property (@(posedge clk) disable iff (rst)
    push.second |-> (phase == PH_LEN) && (rx_byte >= min_length))
    else $error("two results outside a good length byte");

  a_last_leaves_body: assert property (@(posedge clk) disable iff (rst)
    push.first && entry0.frame_last && (phase == PH_BODY) |=> (phase == PH_HUNT))
    else $error("frame end did not resume hunting");

endmodule

`default_nettype wire

>>> rtl/apci_frame_extractor_core.sv
// Top level of the APCI frame extractor: config registers, framing, result queue.
//
//  channel  dir  payload                                          request when
//  rx       in   rx_byte[7:0]                                     valid && ready
//  res      out  out_byte, offset[8:0], frame_first/last, run_last valid && ready
//  cfg      in   cfg_index, cfg_data[7:0]                         cfg_we
//
// One byte is taken per cycle; its results enter the queue at that edge and can
// leave on the next. A good length byte yields two results, so the result side
// moves one per cycle and rx stalls while fewer than two queue slots are free.
// Reset empties the queue, resumes hunting and loads the register defaults.
// A stalled result side holds the head result; rx keeps going until fewer than
// two queue slots are free.
`timescale 1ns / 1ps
`default_nettype none

module apci_frame_extractor_core
  import apci_fx_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  apci_fx_rx_if.sink                rx,
  apci_fx_res_if.source             res,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data
);

  logic [BYTE_W-1:0] start_code;
  logic [BYTE_W-1:0] min_length;
  logic              room;
  logic              take;
  push_t             push;
  res_t              entry0;
  res_t              entry1;
  res_t              head;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code <= START_CODE_RESET;
      min_length <= MIN_LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_CODE: start_code <= cfg_data;
        REG_MIN_LENGTH: min_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rx.ready = room;
  assign take     = rx.valid && room;

  apci_fx_core u_core (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .rx_byte    (rx.rx_byte),
    .start_code (start_code),
    .min_length (min_length),
    .push       (push),
    .entry0     (entry0),
    .entry1     (entry1)
  );

  apci_fx_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .entry0     (entry0),
    .entry1     (entry1),
    .room       (room),
    .head_valid (res.valid),
    .head       (head),
    .head_take  (res.ready)
  );

  assign res.out_byte    = head.out_byte;
  assign res.offset      = head.offset;
  assign res.frame_first = head.frame_first;
  assign res.frame_last  = head.frame_last;
  assign res.run_last    = head.run_last;

  a_first_at_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.frame_first |-> (res.offset == '0))
    else $error("start byte not at offset zero");

  a_open_run_is_start: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.run_last |-> res.frame_first)
    else $error("unfinished run on a byte other than the start byte");

endmodule

`default_nettype wire
